// File: rtl/core/sle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg: shared constants for the serial line editor
// Line store geometry and the control bytes the editor reacts to.
// ----------------------------------------------------------------------------
package sle_pkg;

  // Line store depth; at most LINE_DEPTH-1 characters are kept
  localparam int LINE_DEPTH = 64;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int CHAR_W     = 8;

  // Control bytes
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_CTRL_Z    = 8'h1A;
  localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;

endpackage

// File: rtl/core/sle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; hold data when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/serial_line_editor.sv
`timescale 1ns / 1ps
// Readout: a byte that ends a non-empty line leads through ST_FIRST (read) and ST_LOAD
//   to its first output word; the end-of-file word of an empty line comes from ST_TERM.
// Flow: an ordinary byte, backspace or ignored CR/LF keeps the editor idle and ready; a
//   line of N characters streams out one word per cycle without output stalls (N+1 words,
//   paced by the single read port), and the input is held off until the terminator is sent.
// Reset: fill count and overflow flag clear; line store stays undefined, no clearing pass.
// ----------------------------------------------------------------------------
// serial_line_editor: canonical line editor for received serial bytes
// Collects bytes in a line store, handles backspace, and releases the line
// followed by a newline or end-of-file word on CR/LF or Ctrl-Z.
// ----------------------------------------------------------------------------
module serial_line_editor (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [sle_pkg::CHAR_W-1:0] in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sle_pkg::CHAR_W-1:0] out_char,
  output logic                       out_is_eof,
  output logic                       out_last,
  output logic                       out_overflowed
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LOAD,
    ST_TERM
  } state_t;

  localparam logic [sle_pkg::ADDR_W-1:0] FILL_MAX = sle_pkg::ADDR_W'(sle_pkg::LINE_DEPTH - 1);

  state_t                       state_r, state_nxt;
  logic [sle_pkg::ADDR_W-1:0]   fill_r, fill_nxt;
  logic                         ovf_r, ovf_nxt;
  logic                         eof_r, eof_nxt;
  logic [sle_pkg::ADDR_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [sle_pkg::CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                         out_eof_r, out_eof_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_ovf_r, out_ovf_nxt;

  logic                         in_acc;
  logic                         slot_free;
  logic                         ram_we;
  logic                         ram_re;
  logic [sle_pkg::ADDR_W-1:0]   ram_raddr;
  logic [sle_pkg::CHAR_W-1:0]   ram_rdata;
  logic [sle_pkg::ADDR_W-1:0]   rd_idx_inc;
  logic                         more_chars;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign slot_free  = !out_valid_r || out_ready;
  assign rd_idx_inc = rd_idx_r + sle_pkg::ADDR_W'(1);
  assign more_chars = ({1'b0, rd_idx_inc} < {1'b0, fill_r});

  // Store an ordinary byte while there is room
  assign ram_we = in_acc && (in_rx_byte != sle_pkg::CH_BACKSPACE)
                  && (in_rx_byte != sle_pkg::CH_CTRL_Z)
                  && (in_rx_byte != sle_pkg::CH_CR)
                  && (in_rx_byte != sle_pkg::CH_LF)
                  && (fill_r < FILL_MAX);

  sle_ram #(
    .WIDTH (sle_pkg::CHAR_W),
    .DEPTH (sle_pkg::LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r),
    .wdata (in_rx_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next-state and output register logic
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    eof_nxt       = eof_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_eof_nxt   = out_eof_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    ram_re        = 1'b0;
    ram_raddr     = rd_idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (in_rx_byte == sle_pkg::CH_BACKSPACE) begin
            // Drop the last stored character
            if (fill_r != '0) begin
              fill_nxt = fill_r - sle_pkg::ADDR_W'(1);
            end
          end else if (in_rx_byte == sle_pkg::CH_CTRL_Z ||
                       in_rx_byte == sle_pkg::CH_CR ||
                       in_rx_byte == sle_pkg::CH_LF) begin
            eof_nxt    = (in_rx_byte == sle_pkg::CH_CTRL_Z);
            rd_idx_nxt = '0;
            if (fill_r != '0) begin
              state_nxt = ST_FIRST;
            end else if (in_rx_byte == sle_pkg::CH_CTRL_Z) begin
              state_nxt = ST_TERM;
            end
          end else if (fill_r < FILL_MAX) begin
            fill_nxt = fill_r + sle_pkg::ADDR_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end

      ST_FIRST: begin
        // Fetch the first character
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_nxt = ST_LOAD;
      end

      ST_LOAD: begin
        // Move the fetched character out and prefetch the next one
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ram_rdata;
          out_eof_nxt   = 1'b0;
          out_last_nxt  = 1'b0;
          out_ovf_nxt   = ovf_r;
          if (more_chars) begin
            ram_re     = 1'b1;
            ram_raddr  = rd_idx_inc;
            rd_idx_nxt = rd_idx_inc;
          end else begin
            state_nxt = ST_TERM;
          end
        end
      end

      ST_TERM: begin
        // Close the line with newline or end-of-file word
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = eof_r ? sle_pkg::CH_NUL : sle_pkg::CH_LF;
          out_eof_nxt   = eof_r;
          out_last_nxt  = 1'b1;
          out_ovf_nxt   = ovf_r;
          fill_nxt      = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    eof_r      <= eof_nxt;
    rd_idx_r   <= rd_idx_nxt;
    out_char_r <= out_char_nxt;
    out_eof_r  <= out_eof_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_is_eof     = out_eof_r;
  assign out_last       = out_last_r;
  assign out_overflowed = out_ovf_r;

endmodule

// File: tb/serial_line_editor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_editor_tb: self-checking bench for the serial line editor
// Feeds received bytes (control codes, short and overflowing lines, random
// noise) with random gaps and output stalls, mirrors the line store in a
// scoreboard and compares every emitted word against the predicted line.
// ----------------------------------------------------------------------------
module serial_line_editor_tb;

  localparam int BYTE_TARGET    = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [sle_pkg::CHAR_W-1:0] ch;
    logic                       eof;
    logic                       last;
    logic                       ovf;
  } line_word_t;

  // Mirror of the editor: line store, fill count, drop flag, expected words
  class line_scoreboard;
    logic [sle_pkg::CHAR_W-1:0] line_chars [sle_pkg::LINE_DEPTH];
    logic [sle_pkg::ADDR_W:0]   char_count;
    bit                         chars_dropped;
    line_word_t                 words_due [$];
    int unsigned                errors;

    function new();
      char_count    = '0;
      chars_dropped = 1'b0;
      errors        = 0;
    endfunction

    // Queue the stored line plus its terminator, then clear the line
    function void release_line(bit eof);
      line_word_t w;
      for (int i = 0; i < char_count; i++) begin
        w.ch   = line_chars[i];
        w.eof  = 1'b0;
        w.last = 1'b0;
        w.ovf  = chars_dropped;
        words_due.push_back(w);
      end
      w.ch   = eof ? sle_pkg::CH_NUL : sle_pkg::CH_LF;
      w.eof  = eof;
      w.last = 1'b1;
      w.ovf  = chars_dropped;
      words_due.push_back(w);
      char_count    = '0;
      chars_dropped = 1'b0;
    endfunction

    // Apply one accepted byte to the mirrored line
    function void note_byte(logic [sle_pkg::CHAR_W-1:0] b);
      case (b)
        sle_pkg::CH_BACKSPACE: begin
          if (char_count != 0) char_count = char_count - 1'b1;
        end
        sle_pkg::CH_CTRL_Z: release_line(1'b1);
        sle_pkg::CH_CR, sle_pkg::CH_LF: begin
          if (char_count != 0) release_line(1'b0);
        end
        default: begin
          if (char_count < sle_pkg::LINE_DEPTH - 1) begin
            line_chars[char_count] = b;
            char_count = char_count + 1'b1;
          end else begin
            chars_dropped = 1'b1;
          end
        end
      endcase
    endfunction

    // Compare one emitted word against the oldest expected word
    function void check_word(logic [sle_pkg::CHAR_W-1:0] ch, logic eof, logic last,
                             logic ovf);
      line_word_t w;
      if (words_due.size() == 0) begin
        $error("unexpected word: out_char %0h is_eof %0b last %0b overflowed %0b",
               ch, eof, last, ovf);
        errors++;
        return;
      end
      w = words_due.pop_front();
      if (ch !== w.ch) begin
        $error("out_char: expected %0h, got %0h", w.ch, ch);
        errors++;
      end
      if (eof !== w.eof) begin
        $error("out_is_eof: expected %0b, got %0b", w.eof, eof);
        errors++;
      end
      if (last !== w.last) begin
        $error("out_last: expected %0b, got %0b", w.last, last);
        errors++;
      end
      if (ovf !== w.ovf) begin
        $error("out_overflowed: expected %0b, got %0b", w.ovf, ovf);
        errors++;
      end
    endfunction

    function int unsigned waiting();
      return words_due.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [sle_pkg::CHAR_W-1:0] in_rx_byte;
  logic                       out_valid;
  logic                       out_ready;
  logic [sle_pkg::CHAR_W-1:0] out_char;
  logic                       out_is_eof;
  logic                       out_last;
  logic                       out_overflowed;

  line_scoreboard sb = new();
  int unsigned    bytes_sent;
  int unsigned    idle_cycles;
  bit             calm;

  serial_line_editor dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .out_is_eof    (out_is_eof),
    .out_last      (out_last),
    .out_overflowed(out_overflowed)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Random gap length: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Ordinary character: mostly printable, never a byte the editor treats as a control code
  function automatic logic [sle_pkg::CHAR_W-1:0] pick_char();
    logic [sle_pkg::CHAR_W-1:0] c;
    if ($urandom_range(0, 99) < 80) return sle_pkg::CHAR_W'($urandom_range(8'h20, 8'h7E));
    do c = sle_pkg::CHAR_W'($urandom_range(0, 255));
    while (c == sle_pkg::CH_BACKSPACE || c == sle_pkg::CH_CTRL_Z ||
           c == sle_pkg::CH_CR || c == sle_pkg::CH_LF);
    return c;
  endfunction

  // Offer one byte after a random gap and hold it until accepted
  task automatic send_byte(logic [sle_pkg::CHAR_W-1:0] b);
    repeat (idle_len()) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid   = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // One edited line: characters with stray backspaces, then a terminator
  task automatic send_line(bit overflow);
    int len;
    int t;
    len = overflow ? $urandom_range(sle_pkg::LINE_DEPTH, sle_pkg::LINE_DEPTH + 6)
                   : $urandom_range(0, 12);
    for (int i = 0; i < len; i++) begin
      if (!overflow && $urandom_range(0, 9) == 0) send_byte(sle_pkg::CH_BACKSPACE);
      else send_byte(pick_char());
    end
    // trim after overflow so the drop flag must survive a backspace
    if (overflow && $urandom_range(0, 1)) begin
      repeat ($urandom_range(1, 2)) send_byte(sle_pkg::CH_BACKSPACE);
      send_byte(pick_char());
    end
    t = $urandom_range(0, 2);
    send_byte(t == 0 ? sle_pkg::CH_CR : (t == 1 ? sle_pkg::CH_LF : sle_pkg::CH_CTRL_Z));
  endtask

  // Result side: random stalls, stretches of steady ready
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ready = 1'b0;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if (!calm && $urandom_range(0, 99) < 15) stall_left = idle_len();
      end
    end
  end

  // Monitor both channels at the rising edge; count idle cycles
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_rx_byte);
      if (out_valid && out_ready)
        sb.check_word(out_char, out_is_eof, out_last, out_overflowed);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: end the run if nothing moves for too long
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    logic [sle_pkg::CHAR_W-1:0] opening [] = '{
      sle_pkg::CH_CTRL_Z, sle_pkg::CH_CR, sle_pkg::CH_LF, sle_pkg::CH_BACKSPACE,
      8'h00, 8'hFF, 8'h41, sle_pkg::CH_BACKSPACE, 8'h7F, 8'h80, sle_pkg::CH_CR,
      8'h55, 8'hAA, sle_pkg::CH_LF,
      8'h01, 8'hFE, sle_pkg::CH_BACKSPACE, sle_pkg::CH_BACKSPACE, sle_pkg::CH_BACKSPACE,
      sle_pkg::CH_LF,
      8'h30, sle_pkg::CH_CTRL_Z, sle_pkg::CH_LF
    };
    int line_no;
    int r;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_rx_byte  = '0;
    bytes_sent  = 0;
    idle_cycles = 0;
    calm        = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty-line controls, extreme bytes, backspace edits
    foreach (opening[i]) send_byte(opening[i]);

    // random: mostly well-formed lines, some overflowing, some noise
    line_no = 0;
    while (bytes_sent < BYTE_TARGET) begin
      calm = ($urandom_range(0, 4) == 0);
      if (line_no % 40 == 2) begin
        // hold the sender until the line readout has drained
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.waiting() != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (line_no < 2 || r < 5) begin
        send_line(1'b1);
      end else if (r < 85) begin
        send_line(1'b0);
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(sle_pkg::CHAR_W'($urandom_range(0, 255)));
      end
      line_no++;
    end
    @(negedge clk);
    in_valid = 1'b0;
    calm     = 1'b0;

    // drain outstanding words, then watch for strays
    while (sb.waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.waiting() != 0) begin
      $error("%0d expected words never arrived", sb.waiting());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/sle_pkg.sv
rtl/core/sle_ram.sv
rtl/core/serial_line_editor.sv
tb/serial_line_editor_tb.sv
